// ===== src/zdi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zdi_pkg
// Shared types and codes for the two-wire debug-bus master: command codes,
// sequencer states and the item structures passed between modules.
// ----------------------------------------------------------------------------
package zdi_pkg;

   // Configuration register widths and indexes
   localparam int PHASE_W   = 8;
   localparam int GAP_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_TICKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TICKS   = 1'd1;

   // Command codes
   typedef enum logic [2:0] {
      OP_BEGIN_READ  = 3'd0,
      OP_BEGIN_WRITE = 3'd1,
      OP_READ_BYTE   = 3'd2,
      OP_WRITE_BYTE  = 3'd3,
      OP_END         = 3'd4
   } op_type;

   // Sequencer states, one-hot
   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_START_HI = 11'b000_0000_0010,
      ST_START_LO = 11'b000_0000_0100,
      ST_BIT_LO   = 11'b000_0000_1000,
      ST_BIT_HI   = 11'b000_0001_0000,
      ST_CONT_LO  = 11'b000_0010_0000,
      ST_CONT_HI  = 11'b000_0100_0000,
      ST_GAP_BYTE = 11'b000_1000_0000,
      ST_DONE_LO  = 11'b001_0000_0000,
      ST_DONE_HI  = 11'b010_0000_0000,
      ST_GAP_END  = 11'b100_0000_0000
   } state_type;

   // One input item: one tick of the pin sequencer
   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] op;
      logic [6:0] reg_address;
      logic [7:0] write_data;
      logic       line_in;
   } tick_type;

   // One result item: pin levels and status after the tick
   typedef struct packed {
      logic       clock_out;
      logic       data_out;
      logic       data_drive;
      logic [7:0] read_data;
      logic       read_valid;
      logic       ready_res;
   } pins_type;

endpackage
`default_nettype wire

// ===== src/zdi_debug_bus_master_unit.sv =====
`default_nettype none
// A result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle; the single output register is refilled in
// the cycle it is taken, so input stalls only while a result waits unread.
// Reset: synchronous; clears the sequencer to idle (clock high, line
// released), empties the output register and restores both registers.
// ----------------------------------------------------------------------------
// zdi_debug_bus_master_unit
// Two-wire debug-bus master stepped once per item: start condition, address,
// byte transfers and end sequence, with configurable phase and gap lengths.
// ----------------------------------------------------------------------------
module zdi_debug_bus_master_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input items
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_cmd_valid,
   input  wire logic [2:0]                    req_op,
   input  wire logic [6:0]                    req_reg_address,
   input  wire logic [7:0]                    req_write_data,
   input  wire logic                          req_line_in,
   // result items
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic                          rsp_clock_out,
   output      logic                          rsp_data_out,
   output      logic                          rsp_data_drive,
   output      logic [7:0]                    rsp_read_data,
   output      logic                          rsp_read_valid,
   output      logic                          rsp_ready_res,
   // configuration
   input  wire logic                          csr_write_enable,
   input  wire logic [zdi_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [zdi_pkg::CSR_DAT_W-1:0] csr_write_data
);
   import zdi_pkg::*;

   logic [PHASE_W-1:0] phase_ff;
   logic [GAP_W-1:0]   gap_ff;
   logic               rsp_valid_ff;
   pins_type           rsp_ff;
   pins_type           pins;
   tick_type           tick;
   logic               accept;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_W'(1);
         gap_ff   <= GAP_W'(3);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PHASE_TICKS: phase_ff <= csr_write_data[PHASE_W-1:0];
            CSR_GAP_TICKS:   gap_ff   <= csr_write_data[GAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Accept while the output register is empty or being drained
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      tick.cmd_valid   = req_cmd_valid;
      tick.op          = req_op;
      tick.reg_address = req_reg_address;
      tick.write_data  = req_write_data;
      tick.line_in     = req_line_in;
   end

   zdi_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .tick        (tick),
      .phase_ticks (phase_ff),
      .gap_ticks   (gap_ff),
      .pins        (pins)
   );

   // Output register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= pins;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_clock_out  = rsp_ff.clock_out;
   assign rsp_data_out   = rsp_ff.data_out;
   assign rsp_data_drive = rsp_ff.data_drive;
   assign rsp_read_data  = rsp_ff.read_data;
   assign rsp_read_valid = rsp_ff.read_valid;
   assign rsp_ready_res  = rsp_ff.ready_res;

endmodule
`default_nettype wire

// ===== src/zdi_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zdi_seq
// Pin sequencer of the debug-bus master. Holds the sequence state and
// advances it by one tick for every accepted item; presents the pin levels
// as they stand after that tick.
// ----------------------------------------------------------------------------
module zdi_seq (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire zdi_pkg::tick_type          tick,
   input  wire logic [zdi_pkg::PHASE_W-1:0] phase_ticks,
   input  wire logic [zdi_pkg::GAP_W-1:0]   gap_ticks,
   output      zdi_pkg::pins_type          pins
);
   import zdi_pkg::*;

   state_type     state_ff, state_in;
   logic [3:0]    bit_ff, bit_in;
   logic [7:0]    shift_ff, shift_in;
   logic [GAP_W-1:0] tick_ff, tick_in;
   logic          clk_ff, clk_in;
   logic          data_ff, data_in;
   logic          drive_ff, drive_in;
   logic [7:0]    capt_ff, capt_in;
   logic          rmode_ff, rmode_in;
   logic          valid_in;

   logic [GAP_W-1:0] phase_len;
   logic          gap_state;
   logic          bl_drive, bl_data;

   // Length of the current phase; zero phase_ticks counts as one tick
   always_comb begin
      gap_state = (state_ff == ST_GAP_BYTE) || (state_ff == ST_GAP_END);
      if (gap_state) begin
         phase_len = gap_ticks;
      end else if (phase_ticks == '0) begin
         phase_len = GAP_W'(1);
      end else begin
         phase_len = GAP_W'(phase_ticks);
      end
   end

   // Levels of a clock-low bit phase: released when sampling
   assign bl_drive = !rmode_ff;
   assign bl_data  = rmode_ff ? 1'b0 : shift_ff[7];

   // Advance the sequence by one tick
   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      tick_in  = tick_ff;
      clk_in   = clk_ff;
      data_in  = data_ff;
      drive_in = drive_ff;
      capt_in  = capt_ff;
      rmode_in = rmode_ff;
      valid_in = 1'b0;

      if (state_ff == ST_IDLE) begin
         if (tick.cmd_valid) begin
            case (tick.op)
               OP_BEGIN_READ, OP_BEGIN_WRITE: begin
                  drive_in = 1'b1;
                  rmode_in = 1'b0;
                  shift_in = {tick.reg_address, (tick.op == OP_BEGIN_READ)};
                  bit_in   = '0;
                  clk_in   = 1'b1;
                  data_in  = 1'b1;
                  state_in = ST_START_HI;
                  tick_in  = GAP_W'(1);
               end
               OP_READ_BYTE, OP_WRITE_BYTE: begin
                  drive_in = 1'b1;
                  rmode_in = (tick.op == OP_READ_BYTE);
                  shift_in = (tick.op == OP_WRITE_BYTE) ? tick.write_data : 8'd0;
                  bit_in   = '0;
                  clk_in   = 1'b0;
                  data_in  = 1'b0;
                  state_in = ST_CONT_LO;
                  tick_in  = GAP_W'(1);
               end
               OP_END: begin
                  drive_in = 1'b1;
                  clk_in   = 1'b0;
                  data_in  = 1'b1;
                  state_in = ST_DONE_LO;
                  tick_in  = GAP_W'(1);
               end
               default: begin
                  // unknown command: stay idle
               end
            endcase
         end
      end else if (tick_ff < phase_len) begin
         tick_in = tick_ff + GAP_W'(1);
      end else begin
         tick_in = GAP_W'(1);
         case (state_ff)
            ST_START_HI: begin
               data_in  = 1'b0;
               state_in = ST_START_LO;
            end
            ST_START_LO, ST_GAP_BYTE: begin
               bit_in   = '0;
               clk_in   = 1'b0;
               drive_in = bl_drive;
               data_in  = bl_data;
               state_in = ST_BIT_LO;
            end
            ST_BIT_LO: begin
               clk_in   = 1'b1;
               shift_in = {shift_ff[6:0], rmode_ff & tick.line_in};
               bit_in   = bit_ff + 4'd1;
               state_in = ST_BIT_HI;
            end
            ST_BIT_HI: begin
               if (bit_ff[3]) begin
                  if (rmode_ff) begin
                     capt_in  = shift_ff;
                     valid_in = 1'b1;
                  end
                  state_in = ST_IDLE;
                  tick_in  = '0;
               end else begin
                  clk_in   = 1'b0;
                  drive_in = bl_drive;
                  data_in  = bl_data;
                  state_in = ST_BIT_LO;
               end
            end
            ST_CONT_LO: begin
               clk_in   = 1'b1;
               state_in = ST_CONT_HI;
            end
            ST_CONT_HI: begin
               if (gap_ticks != '0) begin
                  state_in = ST_GAP_BYTE;
               end else begin
                  bit_in   = '0;
                  clk_in   = 1'b0;
                  drive_in = bl_drive;
                  data_in  = bl_data;
                  state_in = ST_BIT_LO;
               end
            end
            ST_DONE_LO: begin
               clk_in   = 1'b1;
               state_in = ST_DONE_HI;
            end
            ST_DONE_HI: begin
               if (gap_ticks != '0) begin
                  state_in = ST_GAP_END;
               end else begin
                  state_in = ST_IDLE;
                  tick_in  = '0;
               end
            end
            default: begin
               state_in = ST_IDLE;
               tick_in  = '0;
            end
         endcase
      end
   end

   // Hold the sequence state between accepted items
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bit_ff   <= '0;
         shift_ff <= '0;
         tick_ff  <= '0;
         clk_ff   <= 1'b1;
         data_ff  <= 1'b0;
         drive_ff <= 1'b0;
         capt_ff  <= '0;
         rmode_ff <= 1'b0;
      end else if (step) begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         tick_ff  <= tick_in;
         clk_ff   <= clk_in;
         data_ff  <= data_in;
         drive_ff <= drive_in;
         capt_ff  <= capt_in;
         rmode_ff <= rmode_in;
      end
   end

   // Present the levels as they stand after this tick
   always_comb begin
      pins.clock_out  = clk_in;
      pins.data_out   = data_in;
      pins.data_drive = drive_in;
      pins.read_data  = capt_in;
      pins.read_valid = valid_in;
      pins.ready_res  = (state_in == ST_IDLE);
   end

endmodule
`default_nettype wire

// ===== verif/zdi_debug_bus_master_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zdi_debug_bus_master_unit_tb
// Drives the debug-bus master one tick per item and checks every result item
// (pin levels, read byte, read strobe, ready) against a cycle model kept in
// the bench. A short directed run covers the field extremes, every command,
// ignored codes, zero and maximum phase and gap lengths and a register change
// mid-sequence. Random command sequences with random idling follow.
// ----------------------------------------------------------------------------
module zdi_debug_bus_master_unit_tb;
   import zdi_pkg::*;

   localparam int          TOTAL_ITEMS    = 390;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          IDLE_PCT       = 17;
   // How the sampled data line behaves during the ticks of a command
   localparam int          LINE_RANDOM    = 0;
   localparam int          LINE_HIGH      = 1;
   localparam int          LINE_LOW       = 2;
   // Command codes that the master must ignore
   localparam logic [2:0]  UNUSED_OP_LO   = 3'd5;
   localparam logic [2:0]  UNUSED_OP_HI   = 3'd7;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic                   req_cmd_valid    = 1'b0;
   logic [2:0]             req_op           = '0;
   logic [6:0]             req_reg_address  = '0;
   logic [7:0]             req_write_data   = '0;
   logic                   req_line_in      = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic                   rsp_clock_out;
   logic                   rsp_data_out;
   logic                   rsp_data_drive;
   logic [7:0]             rsp_read_data;
   logic                   rsp_read_valid;
   logic                   rsp_ready_res;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index        = '0;
   logic [CSR_DAT_W-1:0]   csr_write_data   = '0;

   // Item queues and run statistics
   tick_type               pending_ticks[$];
   pins_type               expected_pins[$];
   int                     sender_gap_pct     = IDLE_PCT;
   int                     receiver_stall_pct = IDLE_PCT;
   int                     error_count        = 0;
   int                     results_checked    = 0;
   int                     bytes_captured     = 0;
   int                     register_writes    = 0;
   int                     stimulus_ticks     = 0;
   int                     quiet_cycles       = 0;

   // Bench copy of the sequencer state and of its two registers
   state_type              seq_state   = ST_IDLE;
   logic [3:0]             bit_count   = '0;
   logic [7:0]             shifter     = '0;
   logic [15:0]            phase_count = '0;
   logic                   clk_lvl     = 1'b1;
   logic                   dat_lvl     = 1'b0;
   logic                   drv_en      = 1'b0;
   logic                   rd_mode     = 1'b0;
   logic [7:0]             last_read   = '0;
   logic [PHASE_W-1:0]     cfg_phase   = 8'd1;
   logic [GAP_W-1:0]       cfg_gap     = 16'd3;

   zdi_debug_bus_master_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd_valid    (req_cmd_valid),
      .req_op           (req_op),
      .req_reg_address  (req_reg_address),
      .req_write_data   (req_write_data),
      .req_line_in      (req_line_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_clock_out    (rsp_clock_out),
      .rsp_data_out     (rsp_data_out),
      .rsp_data_drive   (rsp_data_drive),
      .rsp_read_data    (rsp_read_data),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_ready_res    (rsp_ready_res),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ------------------------------------------------------------------------
   // Sequencer model
   // ------------------------------------------------------------------------
   function automatic logic [15:0] phase_len();
      if (seq_state == ST_GAP_BYTE || seq_state == ST_GAP_END) begin
         return cfg_gap;
      end
      return (cfg_phase == '0) ? 16'd1 : {8'd0, cfg_phase};
   endfunction

   function automatic void goto_state(input state_type next_state);
      seq_state   = next_state;
      phase_count = (next_state == ST_IDLE) ? 16'd0 : 16'd1;
   endfunction

   // Open a bit with the clock low: drive the next bit, or release for a read
   function automatic void open_bit();
      clk_lvl = 1'b0;
      if (rd_mode) begin
         drv_en  = 1'b0;
         dat_lvl = 1'b0;
      end else begin
         drv_en  = 1'b1;
         dat_lvl = shifter[7];
      end
      goto_state(ST_BIT_LO);
   endfunction

   function automatic void end_phase(input logic line, output logic captured);
      captured = 1'b0;
      case (seq_state)
         ST_START_HI: begin
            dat_lvl = 1'b0;
            goto_state(ST_START_LO);
         end
         ST_START_LO, ST_GAP_BYTE: begin
            bit_count = '0;
            open_bit();
         end
         ST_BIT_LO: begin
            clk_lvl   = 1'b1;
            shifter   = {shifter[6:0], rd_mode ? line : 1'b0};
            bit_count = bit_count + 4'd1;
            goto_state(ST_BIT_HI);
         end
         ST_BIT_HI: begin
            if (bit_count >= 4'd8) begin
               if (rd_mode) begin
                  last_read = shifter;
                  captured  = 1'b1;
               end
               goto_state(ST_IDLE);
            end else begin
               open_bit();
            end
         end
         ST_CONT_LO: begin
            clk_lvl = 1'b1;
            goto_state(ST_CONT_HI);
         end
         ST_CONT_HI: begin
            if (cfg_gap != '0) begin
               goto_state(ST_GAP_BYTE);
            end else begin
               bit_count = '0;
               open_bit();
            end
         end
         ST_DONE_LO: begin
            clk_lvl = 1'b1;
            goto_state(ST_DONE_HI);
         end
         ST_DONE_HI: begin
            if (cfg_gap != '0) begin
               goto_state(ST_GAP_END);
            end else begin
               goto_state(ST_IDLE);
            end
         end
         default: begin
            goto_state(ST_IDLE);
         end
      endcase
   endfunction

   // Advance the model by one tick and queue the pin levels it leaves
   function automatic void step_bus_master(input tick_type t);
      pins_type p;
      logic     captured;
      captured = 1'b0;
      if (seq_state == ST_IDLE) begin
         if (t.cmd_valid && t.op <= OP_END) begin
            drv_en = 1'b1;
            case (t.op)
               OP_BEGIN_READ, OP_BEGIN_WRITE: begin
                  rd_mode   = 1'b0;
                  shifter   = {t.reg_address, t.op == OP_BEGIN_READ};
                  bit_count = '0;
                  clk_lvl   = 1'b1;
                  dat_lvl   = 1'b1;
                  goto_state(ST_START_HI);
               end
               OP_READ_BYTE, OP_WRITE_BYTE: begin
                  rd_mode   = (t.op == OP_READ_BYTE);
                  shifter   = (t.op == OP_WRITE_BYTE) ? t.write_data : 8'd0;
                  bit_count = '0;
                  clk_lvl   = 1'b0;
                  dat_lvl   = 1'b0;
                  goto_state(ST_CONT_LO);
               end
               default: begin
                  clk_lvl = 1'b0;
                  dat_lvl = 1'b1;
                  goto_state(ST_DONE_LO);
               end
            endcase
         end
      end else if (phase_count < phase_len()) begin
         phase_count = phase_count + 16'd1;
      end else begin
         end_phase(t.line_in, captured);
      end
      p.clock_out  = clk_lvl;
      p.data_out   = dat_lvl;
      p.data_drive = drv_en;
      p.read_data  = last_read;
      p.read_valid = captured;
      p.ready_res  = (seq_state == ST_IDLE);
      expected_pins.push_back(p);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic tick_type random_tick(input int line_mode);
      tick_type    t;
      logic [31:0] r;
      r = $urandom;
      t = r[$bits(tick_type)-1:0];
      if (line_mode == LINE_HIGH) begin
         t.line_in = 1'b1;
      end else if (line_mode == LINE_LOW) begin
         t.line_in = 1'b0;
      end
      return t;
   endfunction

   // A tick that an idle master must ignore: no command or an unused code
   function automatic tick_type ignored_tick();
      tick_type t;
      t = random_tick(LINE_RANDOM);
      if ($urandom_range(1) == 0) begin
         t.cmd_valid = 1'b0;
      end else begin
         t.cmd_valid = 1'b1;
         t.op        = 3'($urandom_range(UNUSED_OP_HI, UNUSED_OP_LO));
      end
      return t;
   endfunction

   function automatic void queue_tick(input tick_type t, input bit counted);
      pending_ticks.push_back(t);
      if (counted) begin
         stimulus_ticks++;
      end
   endfunction

   // Queue a command tick and the busy ticks it takes under the current
   // settings, so that the next command lands on the first ready tick
   function automatic void push_command(input op_type op, input logic [6:0] addr,
                                        input logic [7:0] data, input int line_mode);
      tick_type t;
      int       p_eff;
      int       busy;
      p_eff = (cfg_phase == '0) ? 1 : int'(cfg_phase);
      case (op)
         OP_BEGIN_READ, OP_BEGIN_WRITE: busy = 18 * p_eff;
         OP_READ_BYTE, OP_WRITE_BYTE:   busy = 18 * p_eff + int'(cfg_gap);
         default:                       busy = 2 * p_eff + int'(cfg_gap);
      endcase
      t             = random_tick(line_mode);
      t.cmd_valid   = 1'b1;
      t.op          = op;
      t.reg_address = addr;
      t.write_data  = data;
      queue_tick(t, 1'b1);
      repeat (busy) queue_tick(random_tick(line_mode), 1'b1);
      // occasionally leave the master idle for a tick or two
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(2, 1)) queue_tick(ignored_tick(), 1'b0);
      end
   endfunction

   function automatic void random_transaction();
      int kind;
      kind = $urandom_range(9);
      if (kind <= 6) begin
         // well-formed access: begin, one to three bytes, end
         push_command(op_type'($urandom_range(1)), 7'($urandom), 8'($urandom), LINE_RANDOM);
         repeat ($urandom_range(3, 1)) begin
            push_command(($urandom_range(1) == 0) ? OP_READ_BYTE : OP_WRITE_BYTE,
                         7'($urandom), 8'($urandom), LINE_RANDOM);
         end
         push_command(OP_END, 7'($urandom), 8'($urandom), LINE_RANDOM);
      end else if (kind == 7) begin
         // byte with no begin in front of it
         push_command(($urandom_range(1) == 0) ? OP_READ_BYTE : OP_WRITE_BYTE,
                      7'($urandom), 8'($urandom), LINE_RANDOM);
      end else if (kind == 8) begin
         // begin with no bytes, end only sometimes
         push_command(op_type'($urandom_range(1)), 7'($urandom), 8'($urandom), LINE_RANDOM);
         if ($urandom_range(1) == 0) begin
            push_command(OP_END, 7'($urandom), 8'($urandom), LINE_RANDOM);
         end
      end else begin
         repeat ($urandom_range(6, 2)) queue_tick(ignored_tick(), 1'b0);
      end
   endfunction

   // Hold until every queued item has gone in and every result has come out
   task automatic wait_all_results();
      @(negedge clock);
      while (pending_ticks.size() != 0 || req_valid || expected_pins.size() != 0) begin
         @(negedge clock);
      end
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] reg_index,
                            input logic [CSR_DAT_W-1:0] value);
      wait_all_results();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= reg_index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (reg_index == CSR_PHASE_TICKS) begin
         cfg_phase = value[PHASE_W-1:0];
      end else begin
         cfg_gap = value[GAP_W-1:0];
      end
      register_writes++;
   endtask

   // ------------------------------------------------------------------------
   // Driver: present the next pending item, idling at random
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_items
      tick_type next_tick;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
            next_tick = pending_ticks.pop_front();
            req_valid       <= 1'b1;
            req_cmd_valid   <= next_tick.cmd_valid;
            req_op          <= next_tick.op;
            req_reg_address <= next_tick.reg_address;
            req_write_data  <= next_tick.write_data;
            req_line_in     <= next_tick.line_in;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // ------------------------------------------------------------------------
   // Monitor: check accepted results, then predict for accepted items
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : watch_results
      pins_type got;
      pins_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_clock_out, rsp_data_out, rsp_data_drive, rsp_read_data,
                   rsp_read_valid, rsp_ready_res};
            if (expected_pins.size() == 0) begin
               $display("%0t: result with none expected, expected none, actual %0h",
                        $time, got);
               error_count++;
            end else begin
               want = expected_pins.pop_front();
               check_field("clock_out", want.clock_out, got.clock_out);
               check_field("data_out", want.data_out, got.data_out);
               check_field("data_drive", want.data_drive, got.data_drive);
               check_field("read_data", want.read_data, got.read_data);
               check_field("read_valid", want.read_valid, got.read_valid);
               check_field("ready_res", want.ready_res, got.ready_res);
            end
            results_checked++;
            if (got.read_valid === 1'b1) begin
               bytes_captured++;
            end
         end
         if (req_valid && !req_stall) begin
            step_bus_master({req_cmd_valid, req_op, req_reg_address, req_write_data,
                             req_line_in});
         end
      end
   end

   // Watchdog: drop the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      tick_type t;
      int       txn_count;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ignored codes and an empty tick while idle
      for (int code = UNUSED_OP_LO; code <= UNUSED_OP_HI; code++) begin
         t           = random_tick(LINE_RANDOM);
         t.cmd_valid = 1'b1;
         t.op        = 3'(code);
         queue_tick(t, 1'b0);
      end
      t           = random_tick(LINE_RANDOM);
      t.cmd_valid = 1'b0;
      t.op        = OP_BEGIN_READ;
      queue_tick(t, 1'b0);

      // reset settings: full read and write accesses with extreme data
      push_command(OP_BEGIN_READ, 7'h7F, 8'h00, LINE_RANDOM);
      push_command(OP_READ_BYTE, 7'h00, 8'h00, LINE_HIGH);
      push_command(OP_READ_BYTE, 7'h7F, 8'hFF, LINE_LOW);
      push_command(OP_END, 7'h00, 8'h00, LINE_RANDOM);
      push_command(OP_BEGIN_WRITE, 7'h00, 8'hFF, LINE_RANDOM);
      push_command(OP_WRITE_BYTE, 7'h7F, 8'hFF, LINE_RANDOM);
      push_command(OP_WRITE_BYTE, 7'h00, 8'h00, LINE_RANDOM);
      push_command(OP_END, 7'h7F, 8'hFF, LINE_RANDOM);
      // byte and end with no begin
      push_command(OP_READ_BYTE, 7'h55, 8'h5A, LINE_RANDOM);
      push_command(OP_END, 7'h2A, 8'hA5, LINE_RANDOM);

      // zero phase length counts as one tick, zero gap skips the gap
      write_csr(CSR_PHASE_TICKS, '0);
      write_csr(CSR_GAP_TICKS, '0);
      push_command(OP_BEGIN_WRITE, 7'h55, 8'h00, LINE_RANDOM);
      push_command(OP_WRITE_BYTE, 7'h00, 8'hAA, LINE_RANDOM);
      push_command(OP_READ_BYTE, 7'h00, 8'h00, LINE_RANDOM);
      push_command(OP_END, 7'h00, 8'h00, LINE_RANDOM);

      // longest phase, shortened while the start condition is four ticks in
      write_csr(CSR_PHASE_TICKS, 16'd255);
      t             = random_tick(LINE_RANDOM);
      t.cmd_valid   = 1'b1;
      t.op          = OP_BEGIN_WRITE;
      t.reg_address = 7'h2A;
      queue_tick(t, 1'b1);
      repeat (3) queue_tick(random_tick(LINE_RANDOM), 1'b1);
      write_csr(CSR_PHASE_TICKS, 16'd1);
      write_csr(CSR_GAP_TICKS, 16'd1);
      repeat (24) queue_tick(ignored_tick(), 1'b0);

      // longest gap, cut short once the end sequence is a few ticks into it
      write_csr(CSR_GAP_TICKS, 16'hFFFF);
      t           = random_tick(LINE_RANDOM);
      t.cmd_valid = 1'b1;
      t.op        = OP_END;
      queue_tick(t, 1'b1);
      repeat (5) queue_tick(random_tick(LINE_RANDOM), 1'b1);
      write_csr(CSR_GAP_TICKS, '0);
      repeat (2) queue_tick(ignored_tick(), 1'b0);

      // random sequences over short phase and gap settings, three per setting;
      // the first three run with no idling on either side
      txn_count = 0;
      while (stimulus_ticks < TOTAL_ITEMS) begin
         if (txn_count % 3 == 0) begin
            write_csr(CSR_PHASE_TICKS, 16'($urandom_range(3)));
            write_csr(CSR_GAP_TICKS, 16'($urandom_range(5)));
            sender_gap_pct     = (txn_count == 0) ? 0 : IDLE_PCT;
            receiver_stall_pct = (txn_count == 0) ? 0 : IDLE_PCT;
         end
         random_transaction();
         txn_count++;
      end

      wait_all_results();
      repeat (4) @(posedge clock);
      $display("Checked %0d result items with %0d bytes read back over %0d register writes,",
               results_checked, bytes_captured, register_writes);
      $display("covering phase lengths 0 to 255 and gap lengths 0 to 65535.");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
